[design/status_led_pattern_engine_defines.svh]
// Assertion macros for the status LED pattern engine.
`ifndef STATUS_LED_PATTERN_ENGINE_DEFINES_SVH
`define STATUS_LED_PATTERN_ENGINE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define SLPE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in this cycle implies a consequence in the next cycle.
`define SLPE_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

[design/slpe_pkg.sv]
// Shared types, codes and helpers for the status LED pattern engine.
`timescale 1ns / 1ps

package slpe_pkg;

    localparam int TIME_WIDTH    = 16;
    localparam int CFG_WIDTH     = 16;
    localparam int CMP_WIDTH     = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;
    localparam int STEP_WIDTH    = 3;
    localparam int PATTERN_STEPS = 7;
    localparam int PAUSE_STEP    = 6;
    localparam int CFG_IDX_WIDTH = 2;

    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

    localparam logic [STEP_WIDTH-1:0] STEP_PAUSE   = STEP_WIDTH'(PAUSE_STEP);
    localparam logic [STEP_WIDTH-1:0] STEP_LAST    = STEP_WIDTH'(PATTERN_STEPS);
    localparam logic [STEP_WIDTH-1:0] STEP_RESTART = STEP_WIDTH'(1);

    // Opcodes
    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_SET_STATUS = 2'd1;
    localparam logic [1:0] OP_PULSE      = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OFF         = 2'd0;
    localparam logic [1:0] ST_CHECKING    = 2'd1;
    localparam logic [1:0] ST_WAIT_UPDATE = 2'd2;
    localparam logic [1:0] ST_JUMP        = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SHORT_STEP = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PAUSE_STEP = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PULSE      = 2'd2;

    localparam logic [CFG_WIDTH-1:0] SHORT_STEP_RESET = CFG_WIDTH'(250);
    localparam logic [CFG_WIDTH-1:0] PAUSE_STEP_RESET = CFG_WIDTH'(1000);
    localparam logic [CFG_WIDTH-1:0] PULSE_RESET      = CFG_WIDTH'(80);

    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] status;
    } item_t;

    typedef struct packed {
        logic                  led_on;
        logic [STEP_WIDTH-1:0] pattern_step;
    } result_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] short_step_ms;
        logic [CFG_WIDTH-1:0] pause_step_ms;
        logic [CFG_WIDTH-1:0] pulse_ms;
    } cfg_t;

    function automatic logic [TIME_WIDTH-1:0] time_sat_inc(input logic [TIME_WIDTH-1:0] v);
        time_sat_inc = (v == TIME_MAX) ? v : v + TIME_WIDTH'(1);
    endfunction

endpackage

[design/slpe_cfg.sv]
// Configuration registers of the status LED pattern engine.
`timescale 1ns / 1ps

module slpe_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [slpe_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [slpe_pkg::CFG_WIDTH-1:0]     cfg_data,
    output slpe_pkg::cfg_t                     cfg
);
    import slpe_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SHORT_STEP: cfg_next.short_step_ms = cfg_data;
                REG_PAUSE_STEP: cfg_next.pause_step_ms = cfg_data;
                REG_PULSE:      cfg_next.pulse_ms      = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_step_ms <= SHORT_STEP_RESET;
            cfg_reg.pause_step_ms <= PAUSE_STEP_RESET;
            cfg_reg.pulse_ms      <= PULSE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/slpe_core.sv]
// LED state and per-item update logic of the status LED pattern engine.
`timescale 1ns / 1ps

module slpe_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  slpe_pkg::item_t   item,
    input  slpe_pkg::cfg_t    cfg,
    output slpe_pkg::result_t result_next
);
    import slpe_pkg::*;

    logic [1:0]            mode_reg,          mode_next;
    logic                  pulse_active_reg,  pulse_active_next;
    logic [TIME_WIDTH-1:0] pulse_elapsed_reg, pulse_elapsed_next;
    logic [TIME_WIDTH-1:0] since_toggle_reg,  since_toggle_next;
    logic [STEP_WIDTH-1:0] wait_step_reg,     wait_step_next;
    logic                  led_level_reg,     led_level_next;

    logic                  run_pattern;
    logic [CFG_WIDTH-1:0]  step_len;
    logic [STEP_WIDTH-1:0] step_inc;

    always_comb
    begin
        mode_next          = mode_reg;
        pulse_active_next  = pulse_active_reg;
        pulse_elapsed_next = pulse_elapsed_reg;
        since_toggle_next  = since_toggle_reg;
        wait_step_next     = wait_step_reg;
        led_level_next     = led_level_reg;
        run_pattern        = 1'b0;
        step_len           = cfg.short_step_ms;
        step_inc           = wait_step_reg;

        case (item.opcode)
            OP_TICK:
            begin
                pulse_elapsed_next = time_sat_inc(pulse_elapsed_reg);
                since_toggle_next  = time_sat_inc(since_toggle_reg);
                run_pattern        = 1'b1;
                if (pulse_active_reg)
                begin
                    if (CMP_WIDTH'(pulse_elapsed_next) < CMP_WIDTH'(cfg.pulse_ms))
                    begin
                        led_level_next = 1'b1;
                        run_pattern    = 1'b0;
                    end
                    else
                    begin
                        // pulse expired: LED follows the status pattern again, pattern restarts at step one
                        pulse_active_next = 1'b0;
                        led_level_next    = 1'b0;
                        since_toggle_next = '0;
                        wait_step_next    = STEP_RESTART;
                    end
                end

                if (run_pattern)
                begin
                    if (mode_reg == ST_WAIT_UPDATE)
                    begin
                        step_len = (wait_step_next == STEP_PAUSE) ? cfg.pause_step_ms
                                                                  : cfg.short_step_ms;
                        if (CMP_WIDTH'(since_toggle_next) >= CMP_WIDTH'(step_len))
                        begin
                            since_toggle_next = '0;
                            step_inc          = wait_step_next + STEP_WIDTH'(1);
                            wait_step_next    = (step_inc >= STEP_LAST) ? '0 : step_inc;
                            led_level_next    = (wait_step_next < STEP_PAUSE)
                                                && !wait_step_next[0];
                        end
                    end
                    else if (mode_reg == ST_CHECKING)
                    begin
                        led_level_next = 1'b1;
                    end
                    else
                    begin
                        led_level_next = 1'b0;
                    end
                end
            end
            OP_SET_STATUS:
            begin
                mode_next         = item.status;
                since_toggle_next = '0;
                pulse_active_next = 1'b0;
                wait_step_next    = '0;
                led_level_next    = (item.status == ST_CHECKING)
                                    || (item.status == ST_WAIT_UPDATE);
            end
            OP_PULSE:
            begin
                pulse_elapsed_next = '0;
                pulse_active_next  = 1'b1;
                led_level_next     = 1'b1;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= ST_OFF;
            pulse_active_reg  <= 1'b0;
            pulse_elapsed_reg <= '0;
            since_toggle_reg  <= '0;
            wait_step_reg     <= '0;
            led_level_reg     <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg          <= mode_next;
            pulse_active_reg  <= pulse_active_next;
            pulse_elapsed_reg <= pulse_elapsed_next;
            since_toggle_reg  <= since_toggle_next;
            wait_step_reg     <= wait_step_next;
            led_level_reg     <= led_level_next;
        end
    end

    assign result_next.led_on       = led_level_next;
    assign result_next.pattern_step = wait_step_next;

endmodule

[design/status_led_pattern_engine.sv]
// Top level of the status LED pattern engine: item and result registers.
`timescale 1ns / 1ps
`include "status_led_pattern_engine_defines.svh"

// Takes one item (tick, set status or activity pulse) per clock cycle while
// item_stall is low and returns one result (LED level, pattern step) per item,
// in order. An accepted item sits in the item register, is applied to the LED
// state by combinational logic and lands in the result register, from which
// its result is offered. Throughput is one item per cycle while the result
// register is not stalled, limited by the single state update per cycle;
// item_stall rises only while the buffered item cannot move because the result
// register is full and stalled. Configuration writes take effect on the next
// clock edge.
module status_led_pattern_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  slpe_pkg::item_t                    item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output slpe_pkg::result_t                  result,
    input  logic                               cfg_write,
    input  logic [slpe_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [slpe_pkg::CFG_WIDTH-1:0]     cfg_data
);
    import slpe_pkg::*;

    logic    item_valid_reg;
    item_t   item_reg;
    logic    result_valid_reg;
    result_t result_reg;
    result_t result_next;
    cfg_t    cfg;
    logic    advance;
    logic    item_take;

    assign advance    = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !advance;
    assign item_take  = item_valid && !item_stall;

    slpe_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    slpe_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item        (item_reg),
        .cfg         (cfg),
        .result_next (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `SLPE_ASSERT(a_step_range, !result_valid_reg || (result_reg.pattern_step < STEP_LAST), "bad step")
    `SLPE_ASSERT_NEXT(a_advance_loads, advance, result_valid_reg, "no result")
    `SLPE_ASSERT_NEXT(a_held_item, item_stall, item_valid_reg && $stable(item_reg), "item lost")

endmodule
